### hdl/oaht_pkg.sv
// Package: shared constants and types of the open-addressing hash table.
package oaht_pkg;
    localparam int SLOTS = 256;
    localparam int IDX_W = $clog2(SLOTS);
    localparam int CNT_W = IDX_W + 1;

    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_GET    = 2'd1;
    localparam logic [1:0] CMD_DELETE = 2'd2;

    localparam logic [1:0] ST_EMPTY = 2'd0;
    localparam logic [1:0] ST_LIVE  = 2'd1;
    localparam logic [1:0] ST_TOMB  = 2'd2;

    localparam logic [2:0] R_NEW       = 3'd0;
    localparam logic [2:0] R_UPDATED   = 3'd1;
    localparam logic [2:0] R_FOUND     = 3'd2;
    localparam logic [2:0] R_NOT_FOUND = 3'd3;
    localparam logic [2:0] R_DELETED   = 3'd4;
    localparam logic [2:0] R_DEL_MISS  = 3'd5;
    localparam logic [2:0] R_FULL      = 3'd6;

    localparam logic [7:0] FILL_LIMIT_RESET = 8'd179;

    // Controller to datapath.
    typedef struct packed {
        logic load;       // capture the item, start the probe at the hash slot
        logic step;       // advance the probe one slot
        logic eval;       // look at the read data of the current slot
        logic commit;     // perform the write and post the result
        logic clear;      // clearing pass write
    } t_dp_cmd;

    // Datapath to controller.
    typedef struct packed {
        logic done;       // probe has finished
        logic clear_last; // clearing pass is at its last slot
    } t_dp_sts;
endpackage

### hdl/oaht_ram.sv
// Generic single-port RAM with registered read.
module oaht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule

### hdl/oaht_dp.sv
// Datapath: slot memories, probe pointer, tombstone tracking and result.
module oaht_dp import oaht_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_dp_cmd     i_cmd,
    input  logic [7:0]  i_fill_limit,
    input  logic [1:0]  i_item_cmd,
    input  logic [63:0] i_key,
    input  logic [31:0] i_key_hash,
    input  logic [63:0] i_value_in,
    output t_dp_sts     o_sts,
    output logic        o_valid,
    output logic [2:0]  o_status,
    output logic [63:0] o_value_out
);
    logic [1:0]       r_cmd;
    logic [63:0]      r_key, r_val;
    logic [IDX_W-1:0] r_idx;
    logic [CNT_W-1:0] r_n, r_used;
    logic             r_hit, r_tomb, r_empty, r_done;
    logic [IDX_W-1:0] r_hit_idx, r_tomb_idx;
    logic [63:0]      r_hit_val;
    logic             r_valid;
    logic [2:0]       r_status;
    logic [63:0]      r_vout;

    logic [IDX_W-1:0] addr;
    logic             we_st, we_kv;
    logic [1:0]       wst;
    logic [1:0]       rd_st;
    logic [63:0]      rd_key, rd_val;

    oaht_ram #(.WIDTH(2),  .DEPTH(SLOTS)) u_st  (.i_clk, .i_we(we_st), .i_addr(addr),
        .i_wdata(wst), .o_rdata(rd_st));
    oaht_ram #(.WIDTH(64), .DEPTH(SLOTS)) u_key (.i_clk, .i_we(we_kv), .i_addr(addr),
        .i_wdata(r_key), .o_rdata(rd_key));
    oaht_ram #(.WIDTH(64), .DEPTH(SLOTS)) u_val (.i_clk, .i_we(we_kv), .i_addr(addr),
        .i_wdata(r_val), .o_rdata(rd_val));

    // Decision made at commit.
    logic [2:0]       c_status;
    logic [IDX_W-1:0] c_addr;
    logic             c_we_st, c_we_kv, c_inc;
    logic [1:0]       c_wst;

    always_comb begin
        c_status = R_NOT_FOUND;
        c_addr   = r_hit_idx;
        c_we_st  = 1'b0;
        c_we_kv  = 1'b0;
        c_wst    = ST_LIVE;
        c_inc    = 1'b0;
        case (r_cmd)
            CMD_INSERT: begin
                if (r_hit) begin
                    c_we_kv = 1'b1; c_status = R_UPDATED;
                end else if (r_tomb) begin
                    c_addr = r_tomb_idx; c_we_kv = 1'b1; c_we_st = 1'b1;
                    c_status = R_NEW;
                end else if (r_empty && ({1'b0, r_used} + 1'b1) <= {2'b0, i_fill_limit}) begin
                    c_addr = r_idx; c_we_kv = 1'b1; c_we_st = 1'b1; c_inc = 1'b1;
                    c_status = R_NEW;
                end else begin
                    c_status = R_FULL;
                end
            end
            CMD_GET:    c_status = r_hit ? R_FOUND : R_NOT_FOUND;
            CMD_DELETE: begin
                if (r_hit) begin
                    c_we_st = 1'b1; c_wst = ST_TOMB; c_status = R_DELETED;
                end else begin
                    c_status = R_DEL_MISS;
                end
            end
            default:    c_status = R_NOT_FOUND;
        endcase
    end

    always_comb begin
        addr  = r_idx;
        we_st = 1'b0;
        we_kv = 1'b0;
        wst   = ST_EMPTY;
        if (i_cmd.clear) begin
            we_st = 1'b1;
        end else if (i_cmd.commit) begin
            addr  = c_addr;
            we_st = c_we_st;
            we_kv = c_we_kv;
            wst   = c_wst;
        end
    end

    assign o_sts.done       = r_done;
    assign o_sts.clear_last = (r_idx == IDX_W'(SLOTS - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= '0;
            r_used  <= '0;
            r_valid <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_valid <= 1'b0;
            if (i_cmd.clear) begin
                r_idx <= r_idx + 1'b1;
            end
            if (i_cmd.load) begin
                r_cmd   <= i_item_cmd;
                r_key   <= i_key;
                r_val   <= i_value_in;
                r_idx   <= i_key_hash[IDX_W-1:0];
                r_n     <= '0;
                r_hit   <= 1'b0;
                r_tomb  <= 1'b0;
                r_empty <= 1'b0;
                r_done  <= (i_item_cmd == 2'd3);
            end
            if (i_cmd.eval) begin
                if (rd_st == ST_EMPTY) begin
                    r_empty <= 1'b1; r_done <= 1'b1;
                end else if (rd_st == ST_TOMB) begin
                    if (!r_tomb) begin
                        r_tomb <= 1'b1; r_tomb_idx <= r_idx;
                    end
                end else if (rd_key == r_key) begin
                    r_hit <= 1'b1; r_hit_idx <= r_idx; r_hit_val <= rd_val;
                    r_done <= 1'b1;
                end
                r_n <= r_n + 1'b1;
                if (r_n == CNT_W'(SLOTS - 1)) begin
                    r_done <= 1'b1;
                end
            end
            // The pointer stays on an empty slot, which an insert then fills.
            if (i_cmd.step && !r_done && rd_st != ST_EMPTY) begin
                r_idx <= r_idx + 1'b1;
            end
            if (i_cmd.commit) begin
                r_valid  <= 1'b1;
                r_status <= c_status;
                r_vout   <= (r_cmd == CMD_GET && r_hit) ? r_hit_val : 64'd0;
                if (c_inc) begin
                    r_used <= r_used + 1'b1;
                end
                r_done <= 1'b0;
            end
        end
    end

    assign o_valid     = r_valid;
    assign o_status    = r_status;
    assign o_value_out = r_vout;
endmodule

### hdl/oaht_ctrl.sv
// Controller: sequences clearing, probing and commit.
module oaht_ctrl import oaht_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_start,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd,
    output logic    o_busy
);
    typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_READ, S_WAIT, S_EVAL, S_COMMIT} t_state;
    t_state r_state;

    always_comb begin
        o_cmd        = '0;
        o_cmd.clear  = (r_state == S_CLEAR);
        o_cmd.load   = (r_state == S_IDLE) && i_start;
        o_cmd.eval   = (r_state == S_EVAL);
        o_cmd.step   = (r_state == S_EVAL);
        o_cmd.commit = (r_state == S_COMMIT);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            o_busy  <= 1'b1;
        end else begin
            unique case (r_state)
                S_CLEAR: if (i_sts.clear_last) begin
                    r_state <= S_IDLE; o_busy <= 1'b0;
                end
                S_IDLE: if (i_start) begin
                    r_state <= S_READ; o_busy <= 1'b1;
                end
                S_READ:  r_state <= i_sts.done ? S_COMMIT : S_WAIT;
                S_WAIT:  r_state <= S_EVAL;
                S_EVAL:  r_state <= S_READ;
                S_COMMIT: begin
                    r_state <= S_IDLE; o_busy <= 1'b0;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

### hdl/open_addressing_hash_table.sv
// Top level: open-addressing hash table with linear probing and tombstones.
// After reset the block sweeps the 256-entry slot status memory to empty,
// one slot a cycle, holding busy high while it sweeps; configuration writes
// are taken during that time. An item is accepted when start is high and
// busy is low. Each probed slot passes through the address, registered
// memory read and evaluate states, with the three slot memories sharing one
// address, and a commit state follows the last probe, after which busy drops.
// The number of slots probed is 0 for the unused command code, otherwise 1
// to 256. The result appears on o_status and o_value_out for one cycle with
// o_valid high, in the first cycle that busy is low; the receiver cannot
// stall it. An unused command code reports not found and changes nothing.
// fill_limit lives at address 0.
module open_addressing_hash_table import oaht_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    output logic        o_busy,
    input  logic [1:0]  i_cmd,
    input  logic [63:0] i_key,
    input  logic [31:0] i_key_hash,
    input  logic [63:0] i_value_in,
    output logic        o_valid,
    output logic [2:0]  o_status,
    output logic [63:0] o_value_out,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    t_dp_cmd    dp_cmd;
    t_dp_sts    dp_sts;
    logic [7:0] r_fill_limit;
    logic       busy;

    assign pready = 1'b1;
    assign prdata = (paddr == 2'd0) ? {24'd0, r_fill_limit} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill_limit <= FILL_LIMIT_RESET;
        end else if (psel && penable && pwrite && paddr == 2'd0) begin
            r_fill_limit <= pwdata[7:0];
        end
    end

    oaht_ctrl u_ctrl (.i_clk, .i_rst_n, .i_start, .i_sts(dp_sts), .o_cmd(dp_cmd),
        .o_busy(busy));

    oaht_dp u_dp (.i_clk, .i_rst_n, .i_cmd(dp_cmd), .i_fill_limit(r_fill_limit),
        .i_item_cmd(i_cmd), .i_key, .i_key_hash, .i_value_in, .o_sts(dp_sts),
        .o_valid, .o_status, .o_value_out);

    assign o_busy = busy;
endmodule

### hdl/oaht_chk.sv
// Checker: port-level properties of the hash table, bound to the top level.
module oaht_chk import oaht_pkg::*; (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_start,
    input logic        o_busy,
    input logic        o_valid,
    input logic [2:0]  o_status,
    input logic [63:0] o_value_out
);
    a_busy_after_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> o_busy) else $error("busy not raised");
    a_valid_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid) else $error("result longer than one cycle");
    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !o_busy) else $error("result while busy");
    a_vout_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != R_FOUND) |-> (o_value_out == 64'd0))
        else $error("value on non-get result");
    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_status != 3'd7)) else $error("bad status");
endmodule

bind open_addressing_hash_table oaht_chk u_chk (.i_clk, .i_rst_n, .i_start, .o_busy,
    .o_valid, .o_status, .o_value_out);

### tb/tb_top.sv
// Testbench for the open-addressing hash table: directed table, then random commands.
`timescale 1ns / 100ps

module tb_top;
    import oaht_pkg::*;

    // Clock, reset and all block inputs start at known values.
    logic        i_clk      = 1'b0;
    logic        i_rst_n    = 1'b0;
    logic        i_start    = 1'b0;
    logic [1:0]  i_cmd      = CMD_GET;
    logic [63:0] i_key      = '0;
    logic [31:0] i_key_hash = '0;
    logic [63:0] i_value_in = '0;
    logic        psel       = 1'b0;
    logic        penable    = 1'b0;
    logic        pwrite     = 1'b0;
    logic [1:0]  paddr      = '0;
    logic [31:0] pwdata     = '0;
    logic        o_busy;
    logic        o_valid;
    logic [2:0]  o_status;
    logic [63:0] o_value_out;
    logic [31:0] prdata;
    logic        pready;

    // The register index of fill_limit, which lives at byte address zero.
    localparam logic [1:0] ADDR_FILL_LIMIT = 2'd0;
    localparam int         CMD_UNUSED      = 3;
    localparam int         KEY_POOL        = 48;
    localparam int         RANDOM_ITEMS    = 1930;
    localparam int         PHASES          = 6;

    typedef struct packed {
        logic [2:0]  status;
        logic [63:0] value;
    } t_lookup;

    typedef struct {
        logic [1:0]  cmd;
        logic [63:0] key;
        logic [31:0] hash;
        logic [63:0] value;
        logic        typed;      // expectation written into the table by hand
        logic [2:0]  exp_status;
        logic [63:0] exp_value;
    } t_row;

    // Shadow copy of the table: slot state, keys, values, fill count and limit.
    logic [1:0]  shadow_state [SLOTS];
    logic [63:0] shadow_keys  [SLOTS];
    logic [63:0] shadow_vals  [SLOTS];
    int unsigned shadow_used;
    logic [7:0]  shadow_limit;

    t_lookup     pending_results[$];
    t_row        directed_rows[$];
    logic [63:0] key_pool [KEY_POOL];
    int          error_count = 0;

    open_addressing_hash_table u_top (.*);

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Applies one command to the shadow table and returns what the block must report.
    // The probe walks from the home slot, remembering the first tombstone, and stops
    // on a live matching key or on an empty slot.
    function automatic t_lookup apply_command(logic [1:0] cmd, logic [63:0] key,
                                              logic [31:0] hash, logic [63:0] value);
        t_lookup     res;
        int unsigned idx;
        int unsigned tomb_idx;
        int unsigned empty_idx;
        int unsigned hit_idx;
        bit          hit;
        bit          tomb;
        bit          empty;
        res.status = R_NOT_FOUND;
        res.value  = '0;
        idx  = hash % SLOTS;
        hit  = 0;
        tomb = 0;
        empty = 0;
        tomb_idx = 0;
        empty_idx = 0;
        hit_idx = 0;
        if (cmd == CMD_UNUSED)
            return res;
        for (int n = 0; n < SLOTS; n++) begin
            if (shadow_state[idx] == ST_EMPTY) begin
                empty = 1;
                empty_idx = idx;
                break;
            end
            if (shadow_state[idx] == ST_TOMB) begin
                if (!tomb) begin
                    tomb = 1;
                    tomb_idx = idx;
                end
            end else if (shadow_keys[idx] == key) begin
                hit = 1;
                hit_idx = idx;
                break;
            end
            idx = (idx + 1) % SLOTS;
        end
        case (cmd)
            CMD_INSERT: begin
                if (hit) begin
                    shadow_vals[hit_idx] = value;
                    res.status = R_UPDATED;
                end else if (tomb) begin
                    // A reused tombstone is already counted, so the limit never applies.
                    shadow_keys[tomb_idx]  = key;
                    shadow_vals[tomb_idx]  = value;
                    shadow_state[tomb_idx] = ST_LIVE;
                    res.status = R_NEW;
                end else if (empty && shadow_used + 1 <= shadow_limit) begin
                    shadow_keys[empty_idx]  = key;
                    shadow_vals[empty_idx]  = value;
                    shadow_state[empty_idx] = ST_LIVE;
                    shadow_used++;
                    res.status = R_NEW;
                end else begin
                    res.status = R_FULL;
                end
            end
            CMD_GET: begin
                if (hit) begin
                    res.status = R_FOUND;
                    res.value  = shadow_vals[hit_idx];
                end
            end
            default: begin
                if (hit) begin
                    shadow_state[hit_idx] = ST_TOMB;
                    res.status = R_DELETED;
                end else begin
                    res.status = R_DEL_MISS;
                end
            end
        endcase
        return res;
    endfunction

    // Every result strobe is matched against the oldest expectation.
    always @(posedge i_clk) begin
        t_lookup exp_res;
        if (i_rst_n && o_valid) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual status %0d value %h",
                         $realtime, o_status, o_value_out);
                error_count++;
            end else begin
                exp_res = pending_results.pop_front();
                if (o_status !== exp_res.status) begin
                    $display("%0t: status mismatch, expected %0d, actual %0d",
                             $realtime, exp_res.status, o_status);
                    error_count++;
                end
                if (o_value_out !== exp_res.value) begin
                    $display("%0t: value_out mismatch, expected %h, actual %h",
                             $realtime, exp_res.value, o_value_out);
                    error_count++;
                end
            end
        end
    end

    // Presents one item and holds it until the block takes it. Returns right
    // after the accepting edge, with start still high.
    task automatic issue_item(logic [1:0] cmd, logic [63:0] key, logic [31:0] hash,
                              logic [63:0] value, logic typed, logic [2:0] exp_status,
                              logic [63:0] exp_value);
        t_lookup predicted;
        i_start    <= 1'b1;
        i_cmd      <= cmd;
        i_key      <= key;
        i_key_hash <= hash;
        i_value_in <= value;
        @(posedge i_clk);
        while (o_busy)
            @(posedge i_clk);
        predicted = apply_command(cmd, key, hash, value);
        if (typed) begin
            predicted.status = exp_status;
            predicted.value  = exp_value;
        end
        pending_results.push_back(predicted);
    endtask

    // Drops start and waits until every outstanding result has come back.
    task automatic drain_results();
        i_start <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Writes fill_limit through the register port, then reads it back.
    task automatic write_fill_limit(logic [7:0] limit);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_FILL_LIMIT;
        pwdata  <= {24'd0, limit};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready)
            @(posedge i_clk);
        shadow_limit = limit;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready)
            @(posedge i_clk);
        if (prdata[7:0] !== limit) begin
            $display("%0t: fill_limit readback mismatch, expected %0d, actual %0d",
                     $realtime, limit, prdata[7:0]);
            error_count++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic add_row(logic [1:0] cmd, logic [63:0] key, logic [31:0] hash,
                           logic [63:0] value, logic typed, logic [2:0] exp_status,
                           logic [63:0] exp_value);
        t_row r;
        r = '{cmd, key, hash, value, typed, exp_status, exp_value};
        directed_rows.push_back(r);
    endtask

    // Hard stop in case the block stops answering.
    initial begin
        #40_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        t_row        r;
        logic [1:0]  cmd;
        logic [63:0] key;
        logic [31:0] hash;
        int unsigned pick;
        int unsigned idle_pct;
        int          phase_items;
        logic [7:0]  phase_limit [PHASES];

        for (int s = 0; s < SLOTS; s++) begin
            shadow_state[s] = ST_EMPTY;
            shadow_keys[s]  = '0;
            shadow_vals[s]  = '0;
        end
        shadow_used  = 0;
        shadow_limit = FILL_LIMIT_RESET;
        for (int k = 0; k < KEY_POOL; k++)
            key_pool[k] = {$urandom, $urandom} | 64'd1;

        // Empty table, extreme keys, updates, the unused command, key zero,
        // a collision chain with a tombstone in the middle that is later reused,
        // and a chain that wraps from the last slot to the first.
        add_row(CMD_GET,    64'd1, 32'd0, 64'd0, 1, R_NOT_FOUND, 64'd0);
        add_row(CMD_DELETE, 64'd1, 32'd0, 64'd0, 1, R_DEL_MISS, 64'd0);
        add_row(CMD_INSERT, '1, '1, '1, 1, R_NEW, 64'd0);
        add_row(CMD_GET,    '1, '1, 64'd0, 1, R_FOUND, '1);
        add_row(CMD_INSERT, '1, '1, 64'd0, 1, R_UPDATED, 64'd0);
        add_row(CMD_GET,    '1, '1, '1, 1, R_FOUND, 64'd0);
        add_row(2'(CMD_UNUSED), '1, '1, '1, 1, R_NOT_FOUND, 64'd0);
        add_row(CMD_INSERT, 64'd0, 32'd0, 64'd5, 1, R_NEW, 64'd0);
        add_row(CMD_GET,    64'd0, 32'd0, 64'd0, 1, R_FOUND, 64'd5);
        add_row(CMD_INSERT, 64'd10, 32'd5, 64'hA, 0, R_NEW, 64'd0);
        add_row(CMD_INSERT, 64'd11, 32'd5, 64'hB, 0, R_NEW, 64'd0);
        add_row(CMD_INSERT, 64'd12, 32'd5, 64'hC, 0, R_NEW, 64'd0);
        add_row(CMD_DELETE, 64'd11, 32'd5, 64'd0, 1, R_DELETED, 64'd0);
        add_row(CMD_GET,    64'd12, 32'h8000_0005, 64'd0, 0, R_NOT_FOUND, 64'd0);
        add_row(CMD_INSERT, 64'd13, 32'd5, 64'hD, 0, R_NEW, 64'd0);
        add_row(CMD_GET,    64'd11, 32'd5, 64'd0, 1, R_NOT_FOUND, 64'd0);
        add_row(CMD_GET,    64'd13, 32'd5, 64'd0, 0, R_NOT_FOUND, 64'd0);
        add_row(CMD_INSERT, 64'd21, 32'h0000_00FF, 64'h21, 0, R_NEW, 64'd0);
        add_row(CMD_GET,    64'd21, 32'h0000_00FF, 64'd0, 0, R_NOT_FOUND, 64'd0);
        add_row(CMD_DELETE, '1, '1, 64'd0, 1, R_DELETED, 64'd0);
        add_row(CMD_DELETE, '1, '1, 64'd0, 1, R_DEL_MISS, 64'd0);

        // Limits per random phase: the extremes, a random one, 40, the maximum again and reset.
        phase_limit[0] = 8'd1;
        phase_limit[1] = 8'd255;
        phase_limit[2] = 8'($urandom_range(1, 255));
        phase_limit[3] = 8'd40;
        phase_limit[4] = 8'd255;
        phase_limit[5] = FILL_LIMIT_RESET;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // The block is still clearing its slots here; the write is allowed then.
        write_fill_limit(FILL_LIMIT_RESET);

        foreach (directed_rows[i]) begin
            r = directed_rows[i];
            issue_item(r.cmd, r.key, r.hash, r.value, r.typed, r.exp_status, r.exp_value);
        end
        drain_results();

        phase_items = RANDOM_ITEMS / PHASES;
        for (int p = 0; p < PHASES; p++) begin
            write_fill_limit(phase_limit[p]);
            // Sender idles 29 percent, then 68 percent, then not at all.
            idle_pct = (p < 2) ? 29 : (p < 4) ? 68 : 0;
            for (int n = 0; n < phase_items; n++) begin
                pick = $urandom_range(0, 99);
                if (pick < 88) begin
                    // Pool keys keep a fixed home slot in a crowded 32-slot region,
                    // so chains, hits and tombstones form; upper hash bits are noise.
                    pick = $urandom_range(0, KEY_POOL - 1);
                    key  = key_pool[pick];
                    hash = {24'($urandom), 8'(pick % 32)};
                    cmd  = 2'($urandom_range(0, 2));
                end else begin
                    key  = {$urandom, $urandom};
                    hash = $urandom;
                    cmd  = 2'($urandom_range(0, 3));
                end
                issue_item(cmd, key, hash, {$urandom, $urandom}, 0, R_NEW, 64'd0);
                if ($urandom_range(0, 99) < idle_pct) begin
                    i_start <= 1'b0;
                    repeat ($urandom_range(1, 8)) @(posedge i_clk);
                end
                // Now and then hold off until the block has answered everything.
                if (n % 150 == 149)
                    drain_results();
            end
            drain_results();
        end

        repeat (20) @(posedge i_clk);
        if (error_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule
